// ===== rtl/vrgt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vrgt_pkg;

  // header length of one game record
  localparam logic [5:0] HEADER_BYTES = 6'd43;

  // result byte kinds
  localparam logic [1:0] KIND_MAGIC  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_POS    = 2'd2;
  localparam logic [1:0] KIND_TERM   = 2'd3;

  // quotient width of the gini divide, one bit per iteration
  localparam int unsigned QUOT_W = 17;

  typedef enum logic [2:0] {
    PH_MAGIC    = 3'd0,
    PH_HEADER   = 3'd1,
    PH_BEST_LO  = 3'd2,
    PH_BEST_HI  = 3'd3,
    PH_SCORE_LO = 3'd4,
    PH_SCORE_HI = 3'd5,
    PH_COUNT    = 3'd6,
    PH_VISIT    = 3'd7
  } phase_e;

  // stream magic "MGC1"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h4D;
      2'd1:    r = 8'h47;
      2'd2:    r = 8'h43;
      default: r = 8'h31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/visit_record_gini_transcoder.sv =====
// each result byte is registered into the output slot once the slot is free;
// a final visit byte passes S_SQUARE, S_PREP and S_LOAD, a divide of 17 quotient bits
// (one quotient bit per cycle in a shared 34-bit compare/subtract) and a clamp step,
// both skipped for a zero visit sum, before its 6 result bytes leave, one per cycle
// when the sink is ready; one request at a time, bytes with no result keep it ready
// reset: asynchronous active low, next request emits the magic first
`timescale 1ns / 1ps
`default_nettype none

module visit_record_gini_transcoder import vrgt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      byte_kind_o,
  output logic            last_in_run_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAGIC, S_HDR, S_TERM, S_SQUARE, S_PREP, S_LOAD, S_DIV, S_POS
  } state_e;

  state_e      state_q;
  phase_e      phase_q;
  logic [5:0]  hdr_left_q;
  logic [15:0] best_q;
  logic [15:0] score_q;
  logic [7:0]  moves_q;
  logic [15:0] sum_q;
  logic [23:0] sq_q;
  logic [7:0]  byte_q;      // latched request byte for the header copy
  logic [2:0]  cnt_q;       // emit index within a burst
  logic [4:0]  div_cnt_q;
  logic [31:0] den_q;       // s*s
  logic [31:0] diff_q;      // s*s - sumsq
  logic [32:0] rem_q;
  logic [QUOT_W-1:0] shf_q; // dividend low bits out the top, quotient bits in
  logic [15:0] q_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [1:0]  out_kind_q;
  logic        out_last_q;

  logic        in_fire;
  logic        slot_free;
  logic        clamp_step;
  logic        out_load;
  logic [5:0]  hdr_eff;
  logic [15:0] b_sq;
  logic [7:0]  moves_dec;
  logic [49:0] dividend;
  logic [32:0] div_d2;
  logic [33:0] div_trial;
  logic [33:0] div_diff;
  logic [7:0]  pos_byte;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign slot_free     = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_kind_o   = out_kind_q;
  assign last_in_run_o = out_last_q;

  // first cycle of a position burst after a divide latches the clamped quotient
  assign clamp_step = (state_q == S_POS) && (cnt_q == 3'd0) && (div_cnt_q == 5'(QUOT_W));

  // a result byte is written into the output slot this cycle
  assign out_load = slot_free && ((state_q == S_MAGIC) || (state_q == S_HDR) ||
                                  (state_q == S_TERM) || ((state_q == S_POS) && !clamp_step));

  // header countdown; the first request after reset opens a fresh header
  assign hdr_eff   = (phase_q == PH_MAGIC) ? HEADER_BYTES : hdr_left_q;
  assign b_sq      = {8'd0, in_byte_i} * {8'd0, in_byte_i};
  assign moves_dec = moves_q - 8'd1;

  // 2*65535*diff + den, formed as (diff << 17) - (diff << 1) + den
  assign dividend = {1'b0, diff_q, 17'd0} - {17'd0, diff_q, 1'b0} + {18'd0, den_q};

  // shared divide step: restoring, one quotient bit per cycle
  assign div_d2    = {den_q, 1'b0};
  assign div_trial = {rem_q, shf_q[QUOT_W-1]};
  assign div_diff  = div_trial - {1'b0, div_d2};

  always_comb begin
    unique case (cnt_q)
      3'd0:    pos_byte = best_q[7:0];
      3'd1:    pos_byte = best_q[15:8];
      3'd2:    pos_byte = score_q[7:0];
      3'd3:    pos_byte = score_q[15:8];
      3'd4:    pos_byte = q_q[7:0];
      default: pos_byte = q_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_MAGIC;
      hdr_left_q  <= '0;
      best_q      <= '0;
      score_q     <= '0;
      moves_q     <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      byte_q      <= '0;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      den_q       <= '0;
      diff_q      <= '0;
      rem_q       <= '0;
      shf_q       <= '0;
      q_q         <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_kind_q  <= KIND_MAGIC;
      out_last_q  <= 1'b0;
    end else begin
      // slot reloads when a byte is written below, else drains once the sink took it
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            byte_q <= in_byte_i;
            cnt_q  <= '0;
            unique case (phase_q) inside
              PH_MAGIC, PH_HEADER: begin
                if (hdr_eff <= 6'd1) begin
                  hdr_left_q <= '0;
                  phase_q    <= PH_BEST_LO;
                end else begin
                  hdr_left_q <= hdr_eff - 6'd1;
                  phase_q    <= PH_HEADER;
                end
                state_q <= (phase_q == PH_MAGIC) ? S_MAGIC : S_HDR;
              end
              PH_BEST_LO: begin
                best_q[7:0] <= in_byte_i;
                phase_q     <= PH_BEST_HI;
              end
              PH_BEST_HI: begin
                best_q[15:8] <= in_byte_i;
                if ((in_byte_i == 8'd0) && (best_q[7:0] == 8'd0)) begin
                  // game over: terminator, then a new header
                  phase_q    <= PH_HEADER;
                  hdr_left_q <= HEADER_BYTES;
                  state_q    <= S_TERM;
                end else begin
                  phase_q <= PH_SCORE_LO;
                end
              end
              PH_SCORE_LO: begin
                score_q[7:0] <= in_byte_i;
                phase_q      <= PH_SCORE_HI;
              end
              PH_SCORE_HI: begin
                score_q[15:8] <= in_byte_i;
                phase_q       <= PH_COUNT;
              end
              PH_COUNT: begin
                moves_q <= in_byte_i;
                sum_q   <= '0;
                sq_q    <= '0;
                if (in_byte_i == 8'd0) begin
                  // no visits: position goes out with zero impurity
                  q_q     <= '0;
                  phase_q <= PH_BEST_LO;
                  state_q <= S_POS;
                end else begin
                  phase_q <= PH_VISIT;
                end
              end
              default: begin
                sum_q   <= sum_q + {8'd0, in_byte_i};
                sq_q    <= sq_q + {8'd0, b_sq};
                moves_q <= moves_dec;
                if (moves_dec == 8'd0) begin
                  phase_q <= PH_BEST_LO;
                  state_q <= S_SQUARE;
                end
              end
            endcase
          end
        end

        S_MAGIC: begin
          if (slot_free) begin
            out_byte_q  <= magic_byte(cnt_q[1:0]);
            out_kind_q  <= KIND_MAGIC;
            out_last_q  <= 1'b0;
            cnt_q       <= cnt_q + 3'd1;
            if (cnt_q == 3'd3) begin
              state_q <= S_HDR;
            end
          end
        end

        S_HDR: begin
          if (slot_free) begin
            out_byte_q  <= byte_q;
            out_kind_q  <= KIND_HEADER;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_TERM: begin
          if (slot_free) begin
            out_byte_q  <= 8'd0;
            out_kind_q  <= KIND_TERM;
            out_last_q  <= (cnt_q == 3'd1);
            cnt_q       <= cnt_q + 3'd1;
            if (cnt_q == 3'd1) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_SQUARE: begin
          den_q   <= {16'd0, sum_q} * {16'd0, sum_q};
          state_q <= S_PREP;
        end

        S_PREP: begin
          if ((den_q == 32'd0) || ({8'd0, sq_q} > den_q)) begin
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_POS;
          end else begin
            diff_q  <= den_q - {8'd0, sq_q};
            state_q <= S_LOAD;
          end
        end

        S_LOAD: begin
          // quotient stays below 2^17, so the upper part starts below 2*den
          rem_q     <= dividend[49:QUOT_W];
          shf_q     <= dividend[QUOT_W-1:0];
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end

        S_DIV: begin
          if (!div_diff[33]) begin
            rem_q <= div_diff[32:0];
            shf_q <= {shf_q[QUOT_W-2:0], 1'b1};
          end else begin
            rem_q <= div_trial[32:0];
            shf_q <= {shf_q[QUOT_W-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'(QUOT_W - 1)) begin
            state_q <= S_POS;
            cnt_q   <= '0;
          end
        end

        S_POS: begin
          // clamp on the final quotient bit
          if (clamp_step) begin
            q_q       <= shf_q[QUOT_W-1] ? 16'hFFFF : shf_q[15:0];
            div_cnt_q <= '0;
          end else if (slot_free) begin
            out_byte_q  <= pos_byte;
            out_kind_q  <= KIND_POS;
            out_last_q  <= (cnt_q == 3'd5);
            cnt_q       <= cnt_q + 3'd1;
            if (cnt_q == 3'd5) begin
              state_q <= S_IDLE;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divide counter never runs past its last quotient bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_cnt_q < 5'(QUOT_W))
    else $error("divide counter overran");

  // while a header is open there is always at least one byte left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> hdr_left_q != 6'd0)
    else $error("open header with no bytes left");

  // magic bytes never close a request's burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == KIND_MAGIC |-> !last_in_run_o)
    else $error("magic byte marked last");

  // a position burst always leaves the parser waiting for the next best move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POS |-> phase_q == PH_BEST_LO)
    else $error("position emitted from wrong phase");

endmodule

`default_nettype wire

// ===== bench/tb_visit_record_gini_transcoder.sv =====
`timescale 1ns / 1ps

module tb_visit_record_gini_transcoder;
  import vrgt_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  // worst case is far below this: ~300 requests, 6 bytes each, long stalls, long divides
  localparam int LIMIT = 500000;
  // divide setup plus iterations plus the six result bytes, with margin
  localparam int DRAIN_CYCLES = 40;
  // room in the stimulus and expectation stores, far above one run
  localparam int STORE_DEPTH = 4096;

  // stream magic, first byte in the top lane
  localparam logic [31:0] MAGIC_WORD = 32'h4D474331;

  // result kind lanes, first result byte in the low bits
  localparam logic [11:0] KD_NONE      = 12'd0;
  localparam logic [11:0] KD_HDR       = 12'(KIND_HEADER);
  localparam logic [11:0] KD_MAGIC_HDR = 12'({KIND_HEADER, {4{KIND_MAGIC}}});
  localparam logic [11:0] KD_POS6      = {6{KIND_POS}};
  localparam logic [11:0] KD_TERM2     = 12'({2{KIND_TERM}});

  // one input request, with an optional typed-in expectation
  // fill > 0 stands for that many random header bytes
  typedef struct packed {
    logic [7:0]  b;
    logic [5:0]  fill;
    logic        typed;
    logic [2:0]  n;
    logic [47:0] ob;
    logic [11:0] kd;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] ob;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // directed part: reset magic, extremes, zero count, zero sum, game end, next header
  localparam int N_DIRECTED = 33;
  localparam byte_req_t DIRECTED [N_DIRECTED] = '{
    // first byte after reset: magic then its own header copy
    '{8'h00, 6'd0, 1'b1, 3'd5, 48'h0000_3143_474D, KD_MAGIC_HDR},
    '{8'hFF, 6'd0, 1'b1, 3'd1, 48'h0000_0000_00FF, KD_HDR},
    '{8'h00, HEADER_BYTES - 6'd2, 1'b0, 3'd0, 48'd0, KD_NONE},
    // best 0x0001, score 0xffff, no visits
    '{8'h01, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'hFF, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'hFF, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b1, 3'd6, 48'h0000_FFFF_0001, KD_POS6},
    // best 0xffff, score 0x8000, one visit of 255 gives q = 0
    '{8'hFF, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'hFF, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h80, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h01, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'hFF, 6'd0, 1'b1, 3'd6, 48'h0000_8000_FFFF, KD_POS6},
    // best 0x8000, score 0x1234, two zero visits: zero sum
    '{8'h00, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h80, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h34, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h12, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h02, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b1, 3'd6, 48'h0000_1234_8000, KD_POS6},
    // best 0xff00 with visits 1 2 3, left to the predictor
    '{8'h00, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'hFF, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'h03, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'h01, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'h02, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    '{8'h03, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE},
    // zero best move ends the game with two terminator bytes
    '{8'h00, 6'd0, 1'b1, 3'd0, 48'd0, KD_NONE},
    '{8'h00, 6'd0, 1'b1, 3'd2, 48'd0, KD_TERM2},
    // next byte opens a fresh header
    '{8'h5A, 6'd0, 1'b1, 3'd1, 48'h0000_0000_005A, KD_HDR},
    '{8'h00, HEADER_BYTES - 6'd1, 1'b0, 3'd0, 48'd0, KD_NONE}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] byte_kind_o;
  logic       last_in_run_o;

  // stimulus and expected result stores, filled at the write index, read in order
  byte_req_t req_mem [STORE_DEPTH];
  int        req_wr = 0;
  int        req_rd = 0;
  out_item_t exp_mem [STORE_DEPTH];
  int        exp_wr = 0;
  int        exp_rd = 0;
  byte_req_t req_cur;
  logic      req_holding = 1'b0;

  // predictor state, mirrors the transcoder
  phase_e      tc_phase = PH_MAGIC;
  logic [5:0]  hdr_left = 6'd0;
  logic [15:0] best_word = 16'd0;
  logic [15:0] score_val = 16'd0;
  logic [7:0]  visits_left = 8'd0;
  logic [15:0] vsum = 16'd0;
  logic [23:0] vsq = 24'd0;
  int          run_len;

  // idle percentages per side
  int send_idle = 0;
  int recv_idle = 0;

  int cycle_cnt = 0;
  int n_errors = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_positions = 0;
  int n_games = 0;

  visit_record_gini_transcoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_kind_o  (byte_kind_o),
    .last_in_run_o(last_in_run_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // quantized gini impurity, exact half-up rounding
  function automatic logic [15:0] gini_quant(input logic [15:0] s, input logic [23:0] sq);
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    den = {48'd0, s} * {48'd0, s};
    if (den == 64'd0 || {40'd0, sq} > den) return 16'd0;
    num = (den - {40'd0, sq}) * 64'd65535;
    q = (64'd2 * num + den) / (64'd2 * den);
    if (q > 64'd65535) q = 64'd65535;
    return q[15:0];
  endfunction

  // append one expected result byte
  task automatic store_expect(input out_item_t item);
    exp_mem[exp_wr] = item;
    exp_wr++;
  endtask

  // one predicted result byte; stored only when this request is not typed in
  task automatic put_byte(input bit keep, input logic [7:0] ob, input logic [1:0] kind);
    run_len++;
    if (keep) store_expect('{ob, kind, 1'b0});
  endtask

  // best, score and q as little-endian bytes
  task automatic emit_position(input bit keep, input logic [15:0] q);
    put_byte(keep, best_word[7:0], KIND_POS);
    put_byte(keep, best_word[15:8], KIND_POS);
    put_byte(keep, score_val[7:0], KIND_POS);
    put_byte(keep, score_val[15:8], KIND_POS);
    put_byte(keep, q[7:0], KIND_POS);
    put_byte(keep, q[15:8], KIND_POS);
    n_positions++;
  endtask

  // advance the predictor by one accepted input byte
  task automatic transcode_byte(input logic [7:0] b, input bit keep);
    logic [23:0] b_sq;
    run_len = 0;
    b_sq = {16'd0, b} * {16'd0, b};
    // magic goes out ahead of the very first byte
    if (tc_phase == PH_MAGIC) begin
      for (int i = 0; i < 4; i++) put_byte(keep, MAGIC_WORD[31 - 8 * i -: 8], KIND_MAGIC);
      tc_phase = PH_HEADER;
      hdr_left = HEADER_BYTES;
    end
    case (tc_phase)
      PH_HEADER: begin
        put_byte(keep, b, KIND_HEADER);
        if (hdr_left <= 6'd1) begin
          hdr_left = 6'd0;
          tc_phase = PH_BEST_LO;
        end else begin
          hdr_left = hdr_left - 6'd1;
        end
      end
      PH_BEST_LO: begin
        best_word = {8'd0, b};
        tc_phase = PH_BEST_HI;
      end
      PH_BEST_HI: begin
        best_word = {b, best_word[7:0]};
        // zero best move ends the game
        if (best_word == 16'd0) begin
          put_byte(keep, 8'd0, KIND_TERM);
          put_byte(keep, 8'd0, KIND_TERM);
          n_games++;
          tc_phase = PH_HEADER;
          hdr_left = HEADER_BYTES;
        end else begin
          tc_phase = PH_SCORE_LO;
        end
      end
      PH_SCORE_LO: begin
        score_val = {8'd0, b};
        tc_phase = PH_SCORE_HI;
      end
      PH_SCORE_HI: begin
        score_val = {b, score_val[7:0]};
        tc_phase = PH_COUNT;
      end
      PH_COUNT: begin
        visits_left = b;
        vsum = 16'd0;
        vsq = 24'd0;
        // no visits: position goes out at once with q = 0
        if (b == 8'd0) begin
          emit_position(keep, 16'd0);
          tc_phase = PH_BEST_LO;
        end else begin
          tc_phase = PH_VISIT;
        end
      end
      PH_VISIT: begin
        vsum = vsum + {8'd0, b};
        vsq = vsq + b_sq;
        visits_left = visits_left - 8'd1;
        if (visits_left == 8'd0) begin
          emit_position(keep, gini_quant(vsum, vsq));
          tc_phase = PH_BEST_LO;
        end
      end
      default: ;
    endcase
    if (keep && run_len > 0) exp_mem[exp_wr - 1].last = 1'b1;
  endtask

  // queue one request for the driver
  task automatic store_req(input byte_req_t r);
    req_mem[req_wr] = r;
    req_wr++;
    n_queued++;
  endtask

  task automatic push_in(input logic [7:0] b);
    store_req('{b, 6'd0, 1'b0, 3'd0, 48'd0, KD_NONE});
  endtask

  // well-formed position with random content, sometimes a lopsided best move
  task automatic gen_position(input bit maxed);
    logic [15:0] best;
    logic [7:0]  cnt;
    int          sel;
    int          mode;
    best = 16'($urandom);
    sel = $urandom_range(7);
    if (sel == 0) best[7:0] = 8'd0;
    else if (sel == 1) best[15:8] = 8'd0;
    if (best == 16'd0) best = 16'h0001;
    push_in(best[7:0]);
    push_in(best[15:8]);
    push_in(8'($urandom));
    push_in(8'($urandom));
    if (maxed) begin
      // a long run of full visits
      cnt = 8'd32;
      mode = 3;
    end else begin
      cnt = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
      mode = $urandom_range(3);
    end
    push_in(cnt);
    for (int i = 0; i < int'(cnt); i++) begin
      case (mode)
        0:       push_in(8'($urandom));
        1:       push_in(8'($urandom_range(3)));
        2:       push_in(8'd0);
        default: push_in(8'hFF);
      endcase
    end
  endtask

  // positions, then optionally stray bytes, game end and the next header
  task automatic gen_chunk(input int n, input bit with_max, input bit with_end);
    int start;
    bit first;
    int nnoise;
    start = n_queued;
    first = with_max;
    while (n_queued - start < n) begin
      gen_position(first);
      first = 1'b0;
    end
    if (with_end) begin
      if ($urandom_range(3) == 0) begin
        nnoise = $urandom_range(1, 6);
        for (int k = 0; k < nnoise; k++) push_in(8'($urandom));
      end
      push_in(8'h00);
      push_in(8'h00);
      for (int k = 0; k < int'(HEADER_BYTES); k++) push_in(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (req_rd != req_wr || req_holding || exp_rd != exp_wr)
      @(posedge clk_i);
  endtask

  // driver and checker, both sampling at the rising edge
  always @(posedge clk_i) begin
    out_item_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      // request taken: run the predictor, or use the typed-in bytes
      if (in_valid_i && in_ready_o) begin
        n_accepted++;
        transcode_byte(req_cur.b, !req_cur.typed);
        if (req_cur.typed)
          for (int i = 0; i < int'(req_cur.n); i++)
            store_expect('{req_cur.ob[8 * i +: 8], req_cur.kd[2 * i +: 2],
                           i == int'(req_cur.n) - 1});
        req_holding = 1'b0;
      end
      // present the next request or idle; a held request stays untouched
      if (!req_holding) begin
        if (req_rd != req_wr && $urandom_range(99) >= send_idle) begin
          req_cur = req_mem[req_rd];
          req_rd++;
          req_holding = 1'b1;
          in_valid_i <= 1'b1;
          in_byte_i <= req_cur.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
      // result byte against the oldest expectation
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (exp_rd == exp_wr) begin
          $display("%0t: unexpected byte %h kind %0d last %0d", $time,
                   out_byte_o, byte_kind_o, last_in_run_o);
          n_errors++;
        end else begin
          want = exp_mem[exp_rd];
          exp_rd++;
          if (out_byte_o !== want.ob) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.ob, out_byte_o);
            n_errors++;
          end
          if (byte_kind_o !== want.kind) begin
            $display("%0t: byte_kind expected %0d actual %0d", $time, want.kind, byte_kind_o);
            n_errors++;
          end
          if (last_in_run_o !== want.last) begin
            $display("%0t: last_in_run expected %0d actual %0d", $time, want.last,
                     last_in_run_o);
            n_errors++;
          end
        end
      end
    end
  end

  // hard stop on a hung run
  initial begin
    while (cycle_cnt < LIMIT) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("tb_visit_record_gini_transcoder: errors");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles more than half as often as the receiver
    send_idle = 36;
    recv_idle = 53;
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].fill != 6'd0) begin
        for (int k = 0; k < int'(DIRECTED[r].fill); k++) push_in(8'($urandom));
      end else begin
        store_req(DIRECTED[r]);
      end
    end
    gen_chunk(40, 1'b0, 1'b0);
    wait_drained();

    // roles swapped, with a game end and a fresh header
    send_idle = 53;
    recv_idle = 36;
    gen_chunk(20, 1'b0, 1'b1);
    wait_drained();

    // full rate, one long position included
    send_idle = 0;
    recv_idle = 0;
    gen_chunk(40, 1'b1, 1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input requests, %0d result bytes checked", n_accepted, n_results);
    $display("including %0d positions and %0d game ends", n_positions, n_games);
    if (n_errors == 0 && exp_rd == exp_wr)
      $display("tb_visit_record_gini_transcoder: clean");
    else
      $display("tb_visit_record_gini_transcoder: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vrgt_pkg.sv
rtl/visit_record_gini_transcoder.sv
bench/tb_visit_record_gini_transcoder.sv
